// ===== src/jss_pkg.sv =====
package jss_pkg;

	localparam int CHUNK_BITS  = 32;
	localparam int PULSE_LIMIT = 32;
	localparam int CNT_CAP     = (CHUNK_BITS < PULSE_LIMIT) ? CHUNK_BITS : PULSE_LIMIT;
	localparam int CNT_W       = $clog2(CNT_CAP + 1);
	localparam int DATA_W      = 32;

	typedef logic [3:0] tap_state_t;

	localparam tap_state_t TAP_TLR        = 4'd0;
	localparam tap_state_t TAP_RTI        = 4'd1;
	localparam tap_state_t TAP_SEL_DR     = 4'd2;
	localparam tap_state_t TAP_CAPTURE_DR = 4'd3;
	localparam tap_state_t TAP_SHIFT_DR   = 4'd4;
	localparam tap_state_t TAP_EXIT1_DR   = 4'd5;
	localparam tap_state_t TAP_PAUSE_DR   = 4'd6;
	localparam tap_state_t TAP_EXIT2_DR   = 4'd7;
	localparam tap_state_t TAP_UPDATE_DR  = 4'd8;
	localparam tap_state_t TAP_SEL_IR     = 4'd9;
	localparam tap_state_t TAP_CAPTURE_IR = 4'd10;
	localparam tap_state_t TAP_SHIFT_IR   = 4'd11;
	localparam tap_state_t TAP_EXIT1_IR   = 4'd12;
	localparam tap_state_t TAP_PAUSE_IR   = 4'd13;
	localparam tap_state_t TAP_EXIT2_IR   = 4'd14;
	localparam tap_state_t TAP_UPDATE_IR  = 4'd15;

	localparam logic OP_MOVE  = 1'b0;
	localparam logic OP_SHIFT = 1'b1;

	// TAP controller successor table, entry is {tms=0, tms=1}
	function automatic tap_state_t tap_next(input tap_state_t cur, input logic tms_lvl);
		tap_state_t nxt0;
		tap_state_t nxt1;
		unique case (cur)
			TAP_TLR:        begin nxt0 = TAP_RTI;        nxt1 = TAP_TLR;       end
			TAP_RTI:        begin nxt0 = TAP_RTI;        nxt1 = TAP_SEL_DR;    end
			TAP_SEL_DR:     begin nxt0 = TAP_CAPTURE_DR; nxt1 = TAP_SEL_IR;    end
			TAP_CAPTURE_DR: begin nxt0 = TAP_SHIFT_DR;   nxt1 = TAP_EXIT1_DR;  end
			TAP_SHIFT_DR:   begin nxt0 = TAP_SHIFT_DR;   nxt1 = TAP_EXIT1_DR;  end
			TAP_EXIT1_DR:   begin nxt0 = TAP_PAUSE_DR;   nxt1 = TAP_UPDATE_DR; end
			TAP_PAUSE_DR:   begin nxt0 = TAP_PAUSE_DR;   nxt1 = TAP_EXIT2_DR;  end
			TAP_EXIT2_DR:   begin nxt0 = TAP_SHIFT_DR;   nxt1 = TAP_UPDATE_DR; end
			TAP_UPDATE_DR:  begin nxt0 = TAP_RTI;        nxt1 = TAP_SEL_DR;    end
			TAP_SEL_IR:     begin nxt0 = TAP_CAPTURE_IR; nxt1 = TAP_TLR;       end
			TAP_CAPTURE_IR: begin nxt0 = TAP_SHIFT_IR;   nxt1 = TAP_EXIT1_IR;  end
			TAP_SHIFT_IR:   begin nxt0 = TAP_SHIFT_IR;   nxt1 = TAP_EXIT1_IR;  end
			TAP_EXIT1_IR:   begin nxt0 = TAP_PAUSE_IR;   nxt1 = TAP_UPDATE_IR; end
			TAP_PAUSE_IR:   begin nxt0 = TAP_PAUSE_IR;   nxt1 = TAP_EXIT2_IR;  end
			TAP_EXIT2_IR:   begin nxt0 = TAP_SHIFT_IR;   nxt1 = TAP_UPDATE_IR; end
			TAP_UPDATE_IR:  begin nxt0 = TAP_RTI;        nxt1 = TAP_SEL_DR;    end
			default:        begin nxt0 = TAP_TLR;        nxt1 = TAP_TLR;       end
		endcase
		return tms_lvl ? nxt1 : nxt0;
	endfunction

endpackage

// ===== src/jss_tap_step.sv =====
// One TCK pulse: pick the TMS level toward a goal and advance the TAP state.
module jss_tap_step (
	input  jss_pkg::tap_state_t cur_state,
	input  jss_pkg::tap_state_t target,
	input  logic                use_target,
	output logic                tms_lvl,
	output jss_pkg::tap_state_t succ_state
);

	jss_pkg::tap_state_t goal;

	// hold goal is the current state itself
	assign goal       = use_target ? target : cur_state;
	assign tms_lvl    = (jss_pkg::tap_next(cur_state, 1'b0) == goal) ? 1'b0 : 1'b1;
	assign succ_state = jss_pkg::tap_next(cur_state, tms_lvl);

endmodule

// ===== src/jtag_scan_sequencer.sv =====
// JTAG master tracking the TAP controller from Test-Logic-Reset. A move item gives one
// TCK pulse; a shift item of n bits (n saturated to 32, zero gives no pulse) gives n
// pulses, one per cycle while the output is not stalled, as the single TAP step unit
// and the TDI shift register step once per pulse. The input is not ready from the
// transfer of an item until its pulses are issued, so a new item waits for the last.
// The input is ready again once the last pulse of an item has been issued into the
// output register; a stalled output holds pulse generation.
module jtag_scan_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [3:0]                    target_state,
	input  logic [jss_pkg::DATA_W-1:0]    data_word,
	input  logic [5:0]                    bit_count,
	input  logic                          last_chunk,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          tms,
	output logic                          tdi,
	output logic [3:0]                    tap_state_after,
	output logic                          last_pulse
);

	localparam logic [5:0]              CAP6 = 6'(jss_pkg::CNT_CAP);
	localparam logic [jss_pkg::CNT_W-1:0] ONE = jss_pkg::CNT_W'(1);

	jss_pkg::tap_state_t           state_q;
	jss_pkg::tap_state_t           target_q;
	logic [jss_pkg::DATA_W-1:0]    data_q;
	logic [jss_pkg::CNT_W-1:0]     remain_q;
	logic                          exit_q;
	logic                          out_valid_q;

	logic                          busy;
	logic                          fire;
	logic                          final_pulse;
	logic                          step_tms;
	jss_pkg::tap_state_t           step_next;
	logic [5:0]                    sat_count;

	assign busy        = (remain_q != '0);
	assign in_ready    = !busy;
	assign fire        = busy && (!out_valid_q || out_ready);
	assign final_pulse = (remain_q == ONE);
	assign sat_count   = (bit_count > CAP6) ? CAP6 : bit_count;

	jss_tap_step u_step (
		.cur_state  (state_q),
		.target     (target_q),
		.use_target (final_pulse && exit_q),
		.tms_lvl    (step_tms),
		.succ_state (step_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= jss_pkg::TAP_TLR;
			remain_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				if (operation == jss_pkg::OP_MOVE) begin
					remain_q <= ONE;
				end else begin
					remain_q <= sat_count[jss_pkg::CNT_W-1:0];
				end
			end else if (fire) begin
				remain_q <= remain_q - ONE;
			end
			if (fire) begin
				state_q     <= step_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			target_q <= target_state;
			if (operation == jss_pkg::OP_MOVE) begin
				data_q <= '0;
				exit_q <= 1'b1;
			end else begin
				data_q <= data_word;
				exit_q <= last_chunk;
			end
		end else if (fire) begin
			data_q <= data_q >> 1;
		end
		if (fire) begin
			tms             <= step_tms;
			tdi             <= data_q[0];
			tap_state_after <= step_next;
			last_pulse      <= final_pulse;
		end
	end

	assign out_valid = out_valid_q;

endmodule
